>>> hdl/rv32i_execute_stage_assert.svh
// Assertion helpers for the execute stage.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef RV32I_EXECUTE_STAGE_ASSERT_SVH
`define RV32I_EXECUTE_STAGE_ASSERT_SVH

// same-cycle implication
`define RV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rv32i_ex_pkg.sv
`timescale 1ns / 1ps

package rv32i_ex_pkg;

    localparam int DATA_BYTES_DEF = 65536;
    localparam int PC_BITS_DEF    = 16;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = 5;
    localparam int PC_PORT_W = 16;
    localparam int IMM_W     = 20;

    localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;

    // major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;

    // instruction formats
    localparam logic [2:0] FMT_R = 3'd0;
    localparam logic [2:0] FMT_I = 3'd1;
    localparam logic [2:0] FMT_S = 3'd2;
    localparam logic [2:0] FMT_B = 3'd3;
    localparam logic [2:0] FMT_U = 3'd4;
    localparam logic [2:0] FMT_J = 3'd5;

    // ALU func3
    localparam logic [2:0] ALU_ADD  = 3'd0;
    localparam logic [2:0] ALU_SLL  = 3'd1;
    localparam logic [2:0] ALU_SLT  = 3'd2;
    localparam logic [2:0] ALU_SLTU = 3'd3;
    localparam logic [2:0] ALU_XOR  = 3'd4;
    localparam logic [2:0] ALU_SR   = 3'd5;
    localparam logic [2:0] ALU_OR   = 3'd6;
    localparam logic [2:0] ALU_AND  = 3'd7;

    // branch func3
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // load func3
    localparam logic [2:0] LD_B  = 3'd0;
    localparam logic [2:0] LD_H  = 3'd1;
    localparam logic [2:0] LD_W  = 3'd2;
    localparam logic [2:0] LD_BU = 3'd4;
    localparam logic [2:0] LD_HU = 3'd5;

    // store size, func3[1:0]
    localparam logic [1:0] ST_B = 2'd0;
    localparam logic [1:0] ST_H = 2'd1;
    localparam logic [1:0] ST_W = 2'd2;

    typedef struct packed {
        logic [XLEN-1:0]      value;
        logic [PC_PORT_W-1:0] next_pc;
        logic [PC_PORT_W-1:0] taken_pc;
        logic                 is_branch;
    } t_exec_res;

endpackage

>>> hdl/rv32i_ex_ram.sv
`timescale 1ns / 1ps

module rv32i_ex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            // write-first on a same-address collision
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rv32i_ex_exec.sv
`timescale 1ns / 1ps

module rv32i_ex_exec #(
    parameter int PC_BITS = rv32i_ex_pkg::PC_BITS_DEF
) (
    input  logic [6:0]                        i_opcode,
    input  logic [2:0]                        i_format,
    input  logic [2:0]                        i_func3,
    input  logic                              i_func7_bit5,
    input  logic [rv32i_ex_pkg::IMM_W-1:0]    i_immediate,
    input  logic [rv32i_ex_pkg::PC_PORT_W-1:0] i_pc,
    input  logic [rv32i_ex_pkg::XLEN-1:0]     i_rv1,
    input  logic [rv32i_ex_pkg::XLEN-1:0]     i_rv2,
    output rv32i_ex_pkg::t_exec_res           o_res
);

    localparam int XL = rv32i_ex_pkg::XLEN;
    localparam int PW = rv32i_ex_pkg::PC_PORT_W;
    localparam logic [XL-1:0] PC_MASK =
        (PC_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PC_BITS) - 64'd1);

    logic [XL-1:0] pc32;
    logic [XL-1:0] imm32;
    logic [XL-1:0] imm_u;
    logic [XL-1:0] imm_b;
    logic [XL-1:0] seq_pc;
    logic [XL-1:0] jump_pc;
    logic [XL-1:0] upper_pc;
    logic [XL-1:0] addr_sum;
    logic [XL-1:0] alu_b;
    logic [4:0]    shamt;
    logic          rtype;
    logic [XL-1:0] alu_out;
    logic          cond;
    logic [XL-1:0] value;
    logic [XL-1:0] npc;

    assign pc32     = {{(XL-PW){1'b0}}, i_pc} & PC_MASK;
    assign imm32    = {{(XL-rv32i_ex_pkg::IMM_W){i_immediate[rv32i_ex_pkg::IMM_W-1]}},
                       i_immediate};
    assign imm_u    = {i_immediate, 12'b0};
    assign imm_b    = {imm32[XL-2:0], 1'b0};
    assign seq_pc   = pc32 + 32'd4;
    assign jump_pc  = pc32 + imm_b;
    assign upper_pc = pc32 + imm_u;
    assign addr_sum = i_rv1 + imm32;
    assign rtype    = (i_format == rv32i_ex_pkg::FMT_R);
    assign alu_b    = rtype ? i_rv2 : imm32;
    assign shamt    = alu_b[4:0];

    always_comb begin
        case (i_func3)
            rv32i_ex_pkg::ALU_ADD:  alu_out = (rtype && i_func7_bit5) ? (i_rv1 - alu_b)
                                                                       : (i_rv1 + alu_b);
            rv32i_ex_pkg::ALU_SLL:  alu_out = i_rv1 << shamt;
            rv32i_ex_pkg::ALU_SLT:  alu_out = {31'b0, $signed(i_rv1) < $signed(alu_b)};
            rv32i_ex_pkg::ALU_SLTU: alu_out = {31'b0, i_rv1 < alu_b};
            rv32i_ex_pkg::ALU_XOR:  alu_out = i_rv1 ^ alu_b;
            rv32i_ex_pkg::ALU_SR:   alu_out = i_func7_bit5 ? $unsigned($signed(i_rv1) >>> shamt)
                                                           : (i_rv1 >> shamt);
            rv32i_ex_pkg::ALU_OR:   alu_out = i_rv1 | alu_b;
            default:                alu_out = i_rv1 & alu_b;
        endcase
    end

    always_comb begin
        case (i_func3)
            rv32i_ex_pkg::BR_EQ:  cond = (i_rv1 == i_rv2);
            rv32i_ex_pkg::BR_NE:  cond = (i_rv1 != i_rv2);
            rv32i_ex_pkg::BR_LT:  cond = ($signed(i_rv1) < $signed(i_rv2));
            rv32i_ex_pkg::BR_GE:  cond = !($signed(i_rv1) < $signed(i_rv2));
            rv32i_ex_pkg::BR_LTU: cond = (i_rv1 < i_rv2);
            rv32i_ex_pkg::BR_GEU: cond = (i_rv1 >= i_rv2);
            default:              cond = 1'b0;
        endcase
    end

    always_comb begin
        value = '0;
        npc   = '0;
        unique case (i_format)
            rv32i_ex_pkg::FMT_R: begin
                value = alu_out;
                npc   = seq_pc;
            end
            rv32i_ex_pkg::FMT_I: begin
                npc = seq_pc;
                if (i_opcode == rv32i_ex_pkg::OPC_JALR) begin
                    value = seq_pc;
                    npc   = addr_sum & rv32i_ex_pkg::JALR_MASK;
                end else if (i_opcode == rv32i_ex_pkg::OPC_LOAD) begin
                    value = addr_sum;
                end else if (i_opcode == rv32i_ex_pkg::OPC_OP_IMM) begin
                    value = alu_out;
                end
            end
            rv32i_ex_pkg::FMT_S: begin
                value = addr_sum;
                npc   = seq_pc;
            end
            rv32i_ex_pkg::FMT_B: begin
                value = {31'b0, cond};
                npc   = seq_pc;
            end
            rv32i_ex_pkg::FMT_U: begin
                value = (i_opcode == rv32i_ex_pkg::OPC_LUI) ? imm_u : upper_pc;
                npc   = seq_pc;
            end
            rv32i_ex_pkg::FMT_J: begin
                value = seq_pc;
                npc   = jump_pc;
            end
            default: begin
                value = '0;
                npc   = '0;
            end
        endcase
    end

    assign o_res.value     = value;
    assign o_res.next_pc   = npc[PW-1:0] & PC_MASK[PW-1:0];
    assign o_res.taken_pc  = jump_pc[PW-1:0] & PC_MASK[PW-1:0];
    assign o_res.is_branch = (i_format == rv32i_ex_pkg::FMT_B);

endmodule

>>> hdl/rv32i_ex_dmem.sv
`timescale 1ns / 1ps

module rv32i_ex_dmem #(
    parameter int DATA_BYTES = rv32i_ex_pkg::DATA_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic                          i_st_en,
    input  logic [rv32i_ex_pkg::XLEN-1:0] i_addr,
    input  logic [1:0]                    i_st_size,
    input  logic [rv32i_ex_pkg::XLEN-1:0] i_st_data,
    input  logic [2:0]                    i_ld_func3,
    input  logic [1:0]                    i_ld_addr_lo,
    output logic [rv32i_ex_pkg::XLEN-1:0] o_ld_value,
    output logic                          o_clr_busy
);

    localparam int MEM_WORDS = DATA_BYTES / 4;
    localparam int IDX_W     = $clog2(MEM_WORDS);
    localparam int XL        = rv32i_ex_pkg::XLEN;

    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic [IDX_W-1:0] word_idx;
    logic [IDX_W-1:0] lane_waddr;
    logic [3:0]       st_lanes;
    logic [3:0]       lane_we;
    logic [XL-1:0]    st_word;
    logic [XL-1:0]    lane_wdata;
    logic [XL-1:0]    rd_word;
    logic [7:0]       ld_byte;
    logic [15:0]      ld_half;

    assign word_idx = i_addr[IDX_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        case (i_st_size)
            rv32i_ex_pkg::ST_B: begin
                st_lanes = 4'b0001 << i_addr[1:0];
                st_word  = {4{i_st_data[7:0]}};
            end
            rv32i_ex_pkg::ST_H: begin
                st_lanes = i_addr[1] ? 4'b1100 : 4'b0011;
                st_word  = {2{i_st_data[15:0]}};
            end
            rv32i_ex_pkg::ST_W: begin
                st_lanes = 4'b1111;
                st_word  = i_st_data;
            end
            default: begin
                st_lanes = 4'b0000;
                st_word  = i_st_data;
            end
        endcase
    end

    assign lane_we    = r_clr_busy ? 4'b1111 : (i_st_en ? st_lanes : 4'b0000);
    assign lane_waddr = r_clr_busy ? r_clr_addr : word_idx;
    assign lane_wdata = r_clr_busy ? '0 : st_word;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        rv32i_ex_ram #(
            .WIDTH (8),
            .DEPTH (MEM_WORDS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (lane_we[g]),
            .i_waddr (lane_waddr),
            .i_wdata (lane_wdata[8*g +: 8]),
            .i_re    (i_rd_en),
            .i_raddr (word_idx),
            .o_rdata (rd_word[8*g +: 8])
        );
    end

    assign ld_byte = rd_word[8*i_ld_addr_lo +: 8];
    assign ld_half = i_ld_addr_lo[1] ? rd_word[31:16] : rd_word[15:0];

    always_comb begin
        case (i_ld_func3)
            rv32i_ex_pkg::LD_B:  o_ld_value = {{24{ld_byte[7]}}, ld_byte};
            rv32i_ex_pkg::LD_H:  o_ld_value = {{16{ld_half[15]}}, ld_half};
            rv32i_ex_pkg::LD_W:  o_ld_value = rd_word;
            rv32i_ex_pkg::LD_BU: o_ld_value = {24'b0, ld_byte};
            rv32i_ex_pkg::LD_HU: o_ld_value = {16'b0, ld_half};
            default:             o_ld_value = '0;
        endcase
    end

    assign o_clr_busy = r_clr_busy;

endmodule

>>> hdl/rv32i_execute_stage.sv
`timescale 1ns / 1ps
// RV32I execute stage: takes one decoded instruction per cycle while o_ready is high and
// returns next_pc, the rd write flag and the rd value through the stage 1, stage 2 and
// result registers, with one result beat per input beat. Reading rs1/rs2 from the
// register file RAMs comes first, then the ALU, branch and pc logic run and the data
// memory access is issued, and last the load data is extracted and rd written back.
// Results of an instruction still in flight, loads included, are forwarded, so dependent
// instructions issue back to back with no stall. After reset the data memory is cleared
// one word per cycle with o_ready low. DATA_BYTES must be a power of two.
`include "rv32i_execute_stage_assert.svh"

module rv32i_execute_stage #(
    parameter int DATA_BYTES = rv32i_ex_pkg::DATA_BYTES_DEF,
    parameter int PC_BITS    = rv32i_ex_pkg::PC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [6:0]                          i_opcode,
    input  logic [2:0]                          i_format,
    input  logic [2:0]                          i_func3,
    input  logic                                i_func7_bit5,
    input  logic [rv32i_ex_pkg::REG_IDX_W-1:0]  i_dest_reg,
    input  logic [rv32i_ex_pkg::REG_IDX_W-1:0]  i_src1_reg,
    input  logic [rv32i_ex_pkg::REG_IDX_W-1:0]  i_src2_reg,
    input  logic signed [rv32i_ex_pkg::IMM_W-1:0] i_immediate,
    input  logic [rv32i_ex_pkg::PC_PORT_W-1:0]  i_pc,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rv32i_ex_pkg::PC_PORT_W-1:0]  o_next_pc,
    output logic                                o_reg_write,
    output logic signed [rv32i_ex_pkg::XLEN-1:0] o_reg_value
);

    localparam int XL = rv32i_ex_pkg::XLEN;
    localparam int RW = rv32i_ex_pkg::REG_IDX_W;
    localparam int PW = rv32i_ex_pkg::PC_PORT_W;

    // stage 1: operand read
    logic                          r_s1_valid;
    logic [6:0]                    r_s1_opcode;
    logic [2:0]                    r_s1_format;
    logic [2:0]                    r_s1_func3;
    logic                          r_s1_func7_bit5;
    logic [RW-1:0]                 r_s1_dest_reg;
    logic [RW-1:0]                 r_s1_src1_reg;
    logic [RW-1:0]                 r_s1_src2_reg;
    logic [rv32i_ex_pkg::IMM_W-1:0] r_s1_immediate;
    logic [PW-1:0]                 r_s1_pc;

    // stage 2: memory
    logic          r_s2_valid;
    logic [XL-1:0] r_s2_value;
    logic [PW-1:0] r_s2_next_pc;
    logic [PW-1:0] r_s2_taken_pc;
    logic          r_s2_is_branch;
    logic          r_s2_is_load;
    logic [2:0]    r_s2_func3;
    logic [1:0]    r_s2_addr_lo;
    logic          r_s2_reg_write;
    logic [RW-1:0] r_s2_dest_reg;

    // result register
    logic          r_out_valid;
    logic [PW-1:0] r_out_next_pc;
    logic          r_out_reg_write;
    logic [XL-1:0] r_out_reg_value;

    logic [rv32i_ex_pkg::REG_COUNT-1:0] r_rf_valid;

    logic                    en_out;
    logic                    en2;
    logic                    en1;
    logic                    accept;
    logic                    clr_busy;
    logic [XL-1:0]           rf1_q;
    logic [XL-1:0]           rf2_q;
    logic                    rf_we;
    logic [XL-1:0]           rv1;
    logic [XL-1:0]           rv2;
    logic                    fwd1;
    logic                    fwd2;
    rv32i_ex_pkg::t_exec_res ex_res;
    logic                    s1_is_load;
    logic                    s1_is_store;
    logic                    s1_reg_write;
    logic                    ld_en;
    logic                    st_en;
    logic [XL-1:0]           ld_value;
    logic [XL-1:0]           s2_value;
    logic [PW-1:0]           s2_next_pc;

    assign en_out  = !r_out_valid || i_ready;
    assign en2     = !r_s2_valid || en_out;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1 && !clr_busy;
    assign accept  = i_valid && o_ready;

    // register file, duplicated for two read ports
    assign rf_we = en_out && r_s2_valid && r_s2_reg_write;

    rv32i_ex_ram #(
        .WIDTH (XL),
        .DEPTH (rv32i_ex_pkg::REG_COUNT)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2_dest_reg),
        .i_wdata (s2_value),
        .i_re    (accept),
        .i_raddr (i_src1_reg),
        .o_rdata (rf1_q)
    );

    rv32i_ex_ram #(
        .WIDTH (XL),
        .DEPTH (rv32i_ex_pkg::REG_COUNT)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2_dest_reg),
        .i_wdata (s2_value),
        .i_re    (accept),
        .i_raddr (i_src2_reg),
        .o_rdata (rf2_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
        end else if (rf_we) begin
            r_rf_valid[r_s2_dest_reg] <= 1'b1;
        end
    end

    // only the stage 2 instruction can be unwritten when stage 1 reads
    assign fwd1 = r_s2_valid && r_s2_reg_write && (r_s2_dest_reg == r_s1_src1_reg);
    assign fwd2 = r_s2_valid && r_s2_reg_write && (r_s2_dest_reg == r_s1_src2_reg);
    assign rv1  = fwd1 ? s2_value : (r_rf_valid[r_s1_src1_reg] ? rf1_q : '0);
    assign rv2  = fwd2 ? s2_value : (r_rf_valid[r_s1_src2_reg] ? rf2_q : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_opcode     <= i_opcode;
            r_s1_format     <= i_format;
            r_s1_func3      <= i_func3;
            r_s1_func7_bit5 <= i_func7_bit5;
            r_s1_dest_reg   <= i_dest_reg;
            r_s1_src1_reg   <= i_src1_reg;
            r_s1_src2_reg   <= i_src2_reg;
            r_s1_immediate  <= $unsigned(i_immediate);
            r_s1_pc         <= i_pc;
        end
    end

    rv32i_ex_exec #(
        .PC_BITS (PC_BITS)
    ) u_exec (
        .i_opcode     (r_s1_opcode),
        .i_format     (r_s1_format),
        .i_func3      (r_s1_func3),
        .i_func7_bit5 (r_s1_func7_bit5),
        .i_immediate  (r_s1_immediate),
        .i_pc         (r_s1_pc),
        .i_rv1        (rv1),
        .i_rv2        (rv2),
        .o_res        (ex_res)
    );

    assign s1_is_load   = (r_s1_opcode == rv32i_ex_pkg::OPC_LOAD);
    assign s1_is_store  = (r_s1_opcode == rv32i_ex_pkg::OPC_STORE);
    assign s1_reg_write = (r_s1_dest_reg != '0)
                          && (r_s1_opcode != rv32i_ex_pkg::OPC_BRANCH) && !s1_is_store;
    assign ld_en        = en2 && r_s1_valid && s1_is_load;
    assign st_en        = en2 && r_s1_valid && s1_is_store;

    rv32i_ex_dmem #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dmem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (ld_en),
        .i_st_en      (st_en),
        .i_addr       (ex_res.value),
        .i_st_size    (r_s1_func3[1:0]),
        .i_st_data    (rv2),
        .i_ld_func3   (r_s2_func3),
        .i_ld_addr_lo (r_s2_addr_lo),
        .o_ld_value   (ld_value),
        .o_clr_busy   (clr_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_valid) begin
            r_s2_value     <= ex_res.value;
            r_s2_next_pc   <= ex_res.next_pc;
            r_s2_taken_pc  <= ex_res.taken_pc;
            r_s2_is_branch <= ex_res.is_branch;
            r_s2_is_load   <= s1_is_load;
            r_s2_func3     <= r_s1_func3;
            r_s2_addr_lo   <= ex_res.value[1:0];
            r_s2_reg_write <= s1_reg_write;
            r_s2_dest_reg  <= r_s1_dest_reg;
        end
    end

    // branch outcome uses the final value, after any load
    assign s2_value   = r_s2_is_load ? ld_value : r_s2_value;
    assign s2_next_pc = (r_s2_is_branch && s2_value[0]) ? r_s2_taken_pc : r_s2_next_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_valid) begin
            r_out_next_pc   <= s2_next_pc;
            r_out_reg_write <= r_s2_reg_write;
            r_out_reg_value <= s2_value;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_next_pc   = r_out_next_pc;
    assign o_reg_write = r_out_reg_write;
    assign o_reg_value = $signed(r_out_reg_value);

    `RV_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !o_ready, "input beat during memory clear")
    `RV_ASSERT_NOW(a_no_store_in_clear, clr_busy, !st_en, "store issued during memory clear")
    `RV_ASSERT_NOW(a_x0_never_written, 1'b1, !r_rf_valid[0], "x0 marked written")
    `RV_ASSERT_NOW(a_hold_no_writeback, r_s1_valid && !en2, !rf_we,
                   "register write while stage 1 holds its operands")
    `RV_ASSERT_NEXT(a_s2_reaches_out, r_s2_valid && en_out, r_out_valid,
                    "stage 2 beat lost on the way to the result register")

endmodule

>>> tb/rv32i_execute_checker.sv
`timescale 1ns / 1ps

module rv32i_execute_checker
    import rv32i_ex_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [6:0]           i_opcode,
    input  logic [2:0]           i_format,
    input  logic [2:0]           i_func3,
    input  logic                 i_func7_bit5,
    input  logic [REG_IDX_W-1:0] i_dest_reg,
    input  logic [REG_IDX_W-1:0] i_src1_reg,
    input  logic [REG_IDX_W-1:0] i_src2_reg,
    input  logic [IMM_W-1:0]     i_immediate,
    input  logic [PC_PORT_W-1:0] i_pc,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [PC_PORT_W-1:0] i_next_pc,
    input  logic                 i_reg_write,
    input  logic [XLEN-1:0]      i_reg_value,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int MEM_WORDS = DATA_BYTES_DEF / 4;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int MAX_LINES = 100;

    typedef struct packed {
        logic [PC_PORT_W-1:0] next_pc;
        logic                 reg_write;
        logic [XLEN-1:0]      reg_value;
    } retire_t;

    logic [XLEN-1:0] gpr [REG_COUNT];
    logic [XLEN-1:0] dmem [MEM_WORDS];
    retire_t         pending_retires [$];
    retire_t         want;
    int              fail_cnt = 0;
    int              out_beats = 0;

    assign o_fail_count = fail_cnt;

    function automatic logic [XLEN-1:0] alu_result(input logic [XLEN-1:0] a,
                                                   input logic [XLEN-1:0] b,
                                                   input logic [2:0] f3,
                                                   input logic sub_en,
                                                   input logic arith);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            ALU_ADD:  return sub_en ? a - b : a + b;
            ALU_SLL:  return a << sh;
            ALU_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            ALU_SLTU: return (a < b) ? 32'd1 : 32'd0;
            ALU_XOR:  return a ^ b;
            ALU_SR: begin
                if (arith)
                    return $signed(a) >>> sh;
                return a >> sh;
            end
            ALU_OR:   return a | b;
            default:  return a & b;
        endcase
    endfunction

    function automatic logic branch_taken(input logic [XLEN-1:0] a,
                                          input logic [XLEN-1:0] b,
                                          input logic [2:0] f3);
        case (f3)
            BR_EQ:   return a == b;
            BR_NE:   return a != b;
            BR_LT:   return $signed(a) < $signed(b);
            BR_GE:   return !($signed(a) < $signed(b));
            BR_LTU:  return a < b;
            BR_GEU:  return a >= b;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [XLEN-1:0] load_value(input logic [XLEN-1:0] addr,
                                                   input logic [2:0] f3);
        logic [XLEN-1:0] w;
        logic [7:0]      b;
        logic [15:0]     h;
        w = dmem[addr[MEM_AW+1:2]];
        b = w[{addr[1:0], 3'b000} +: 8];
        h = addr[1] ? w[31:16] : w[15:0];
        case (f3)
            LD_B:    return {{24{b[7]}}, b};
            LD_H:    return {{16{h[15]}}, h};
            LD_W:    return w;
            LD_BU:   return {24'd0, b};
            LD_HU:   return {16'd0, h};
            default: return '0;
        endcase
    endfunction

    function automatic void store_value(input logic [XLEN-1:0] addr,
                                        input logic [XLEN-1:0] v,
                                        input logic [2:0] f3);
        logic [XLEN-1:0] w;
        w = dmem[addr[MEM_AW+1:2]];
        case (f3[1:0])
            ST_B: w[{addr[1:0], 3'b000} +: 8] = v[7:0];
            ST_H: w[{addr[1], 4'b0000} +: 16] = v[15:0];
            ST_W: w = v;
            default: return;
        endcase
        dmem[addr[MEM_AW+1:2]] = w;
    endfunction

    function automatic retire_t retire_instr(input logic [6:0] opc,
                                             input logic [2:0] fmt,
                                             input logic [2:0] f3,
                                             input logic f7,
                                             input logic [REG_IDX_W-1:0] rd,
                                             input logic [REG_IDX_W-1:0] rs1,
                                             input logic [REG_IDX_W-1:0] rs2,
                                             input logic [IMM_W-1:0] imm,
                                             input logic [PC_PORT_W-1:0] pc);
        logic [XLEN-1:0] imm_x;
        logic [XLEN-1:0] pc_x;
        logic [XLEN-1:0] rv1;
        logic [XLEN-1:0] rv2;
        logic [XLEN-1:0] res;
        logic [XLEN-1:0] npc;
        logic            wr;
        retire_t         r;

        imm_x = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
        pc_x  = {{(XLEN-PC_PORT_W){1'b0}}, pc};
        rv1   = gpr[rs1];
        rv2   = gpr[rs2];

        case (fmt)
            FMT_R: res = alu_result(rv1, rv2, f3, f7, f7);
            FMT_I: begin
                if (opc == OPC_JALR)
                    res = pc_x + 32'd4;
                else if (opc == OPC_LOAD)
                    res = rv1 + imm_x;
                else if (opc == OPC_OP_IMM)
                    res = alu_result(rv1, imm_x, f3, 1'b0, f7);
                else
                    res = '0;
            end
            FMT_S: res = rv1 + imm_x;
            FMT_B: res = {31'd0, branch_taken(rv1, rv2, f3)};
            FMT_U: res = (opc == OPC_LUI) ? (imm_x << 12) : pc_x + (imm_x << 12);
            FMT_J: res = pc_x + 32'd4;
            default: res = '0;
        endcase

        if (opc == OPC_STORE)
            store_value(res, rv2, f3);
        if (opc == OPC_LOAD)
            res = load_value(res, f3);

        wr = (rd != '0) && (opc != OPC_BRANCH) && (opc != OPC_STORE);
        if (wr)
            gpr[rd] = res;

        case (fmt)
            FMT_R, FMT_S, FMT_U: npc = pc_x + 32'd4;
            FMT_I: npc = (opc == OPC_JALR) ? ((rv1 + imm_x) & JALR_MASK) : pc_x + 32'd4;
            FMT_B: npc = res[0] ? pc_x + (imm_x << 1) : pc_x + 32'd4;
            FMT_J: npc = pc_x + (imm_x << 1);
            default: npc = '0;
        endcase

        r.next_pc   = npc[PC_PORT_W-1:0];
        r.reg_write = wr;
        r.reg_value = res;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                   input logic [XLEN-1:0] exp_v);
        if (fail_cnt < MAX_LINES)
            $display("rv32i_execute_checker: result beat %0d %s: got %h, expected %h",
                     out_beats, what, got, exp_v);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++)
                gpr[k] = '0;
            for (int k = 0; k < MEM_WORDS; k++)
                dmem[k] = '0;
            pending_retires.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_retires.size() == 0) begin
                    report_mismatch("unexpected beat, reg_value", i_reg_value, '0);
                end else begin
                    want = pending_retires.pop_front();
                    if (i_next_pc !== want.next_pc)
                        report_mismatch("next_pc", i_next_pc, want.next_pc);
                    if (i_reg_write !== want.reg_write)
                        report_mismatch("reg_write", i_reg_write, want.reg_write);
                    if (i_reg_value !== want.reg_value)
                        report_mismatch("reg_value", i_reg_value, want.reg_value);
                end
                out_beats++;
            end
            if (i_in_valid && i_in_ready)
                pending_retires.push_back(retire_instr(i_opcode, i_format, i_func3,
                    i_func7_bit5, i_dest_reg, i_src1_reg, i_src2_reg, i_immediate, i_pc));
        end
        o_pending <= pending_retires.size();
    end

endmodule

>>> tb/rv32i_execute_stage_test.sv
`timescale 1ns / 1ps

module rv32i_execute_stage_test;
    import rv32i_ex_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 4 * (DATA_BYTES_DEF / 4) + 4 * HOLD_CYCLES;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [2:0] FMT_BAD    = 3'd7;
    localparam logic [2:0] ST_RSVD    = 3'd3;
    localparam logic [2:0] LD_RSVD    = 3'd6;
    localparam logic [2:0] BR_RSVD    = 3'd2;

    typedef struct packed {
        logic [6:0]           opcode;
        logic [2:0]           format;
        logic [2:0]           func3;
        logic                 func7_bit5;
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] rs1;
        logic [REG_IDX_W-1:0] rs2;
        logic [IMM_W-1:0]     imm;
        logic [PC_PORT_W-1:0] pc;
    } instr_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [6:0]           opcode = '0;
    logic [2:0]           format = '0;
    logic [2:0]           func3 = '0;
    logic                 func7_bit5 = 1'b0;
    logic [REG_IDX_W-1:0] dest_reg = '0;
    logic [REG_IDX_W-1:0] src1_reg = '0;
    logic [REG_IDX_W-1:0] src2_reg = '0;
    logic [IMM_W-1:0]     immediate = '0;
    logic [PC_PORT_W-1:0] pc = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PC_PORT_W-1:0] next_pc;
    logic                 reg_write;
    logic [XLEN-1:0]      reg_value;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    bit steady = 1'b0;

    always #2 clk = ~clk;

    rv32i_execute_stage uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_opcode     (opcode),
        .i_format     (format),
        .i_func3      (func3),
        .i_func7_bit5 (func7_bit5),
        .i_dest_reg   (dest_reg),
        .i_src1_reg   (src1_reg),
        .i_src2_reg   (src2_reg),
        .i_immediate  (immediate),
        .i_pc         (pc),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_next_pc    (next_pc),
        .o_reg_write  (reg_write),
        .o_reg_value  (reg_value)
    );

    rv32i_execute_checker retire_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_opcode     (opcode),
        .i_format     (format),
        .i_func3      (func3),
        .i_func7_bit5 (func7_bit5),
        .i_dest_reg   (dest_reg),
        .i_src1_reg   (src1_reg),
        .i_src2_reg   (src2_reg),
        .i_immediate  (immediate),
        .i_pc         (pc),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_next_pc    (next_pc),
        .i_reg_write  (reg_write),
        .i_reg_value  (reg_value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic instr_t mk(input logic [6:0] opc, input logic [2:0] fmt,
                                  input logic [2:0] f3, input logic f7,
                                  input logic [4:0] rd, input logic [4:0] rs1,
                                  input logic [4:0] rs2, input logic [19:0] imm,
                                  input logic [15:0] at_pc);
        instr_t ins;
        ins.opcode     = opc;
        ins.format     = fmt;
        ins.func3      = f3;
        ins.func7_bit5 = f7;
        ins.rd         = rd;
        ins.rs1        = rs1;
        ins.rs2        = rs2;
        ins.imm        = imm;
        ins.pc         = at_pc;
        return ins;
    endfunction

    function automatic instr_t rand_instr();
        instr_t     ins;
        int         pick;
        int         off;
        logic [11:0] imm12;
        logic [19:0] imm_s12;

        ins.opcode     = 7'($urandom_range(0, 127));
        ins.format     = 3'($urandom_range(0, 7));
        ins.func3      = 3'($urandom_range(0, 7));
        ins.func7_bit5 = 1'($urandom_range(0, 1));
        ins.rd         = 5'($urandom_range(0, 31));
        ins.rs1        = 5'($urandom_range(0, 31));
        ins.rs2        = 5'($urandom_range(0, 31));
        ins.imm        = 20'($urandom_range(0, 20'hFFFFF));
        ins.pc         = 16'($urandom_range(0, 16'hFFFF));
        imm12          = 12'($urandom_range(0, 12'hFFF));
        imm_s12        = {{8{imm12[11]}}, imm12};
        off            = int'($urandom_range(0, 127)) - 64;
        pick           = $urandom_range(0, 99);

        if (pick < 20) begin
            ins.opcode = OPC_OP;
            ins.format = FMT_R;
        end else if (pick < 38) begin
            ins.opcode = OPC_OP_IMM;
            ins.format = FMT_I;
            ins.imm    = imm_s12;
        end else if (pick < 66) begin
            if (pick < 52) begin
                ins.opcode = OPC_LOAD;
                ins.format = FMT_I;
                case ($urandom_range(0, 5))
                    0: ins.func3 = LD_B;
                    1: ins.func3 = LD_H;
                    2: ins.func3 = LD_W;
                    3: ins.func3 = LD_BU;
                    4: ins.func3 = LD_HU;
                    default: ins.func3 = LD_RSVD;
                endcase
            end else begin
                ins.opcode = OPC_STORE;
                ins.format = FMT_S;
            end
            // keep most accesses in a small window so loads see earlier stores
            if ($urandom_range(0, 9) < 7) begin
                ins.rs1 = '0;
                ins.imm = 20'(off);
            end else begin
                ins.imm = imm_s12;
            end
        end else if (pick < 78) begin
            ins.opcode = OPC_BRANCH;
            ins.format = FMT_B;
            ins.imm    = imm_s12;
            if ($urandom_range(0, 3) == 0)
                ins.rs2 = ins.rs1;
        end else if (pick < 83) begin
            ins.opcode = OPC_JAL;
            ins.format = FMT_J;
        end else if (pick < 88) begin
            ins.opcode = OPC_JALR;
            ins.format = FMT_I;
            ins.imm    = imm_s12;
        end else if (pick < 93) begin
            ins.opcode = $urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC;
            ins.format = FMT_U;
        end
        return ins;
    endfunction

    task automatic issue(input instr_t ins);
        while (!steady && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= ins.opcode;
        format     <= ins.format;
        func3      <= ins.func3;
        func7_bit5 <= ins.func7_bit5;
        dest_reg   <= ins.rd;
        src1_reg   <= ins.rs1;
        src2_reg   <= ins.rs2;
        immediate  <= ins.imm;
        pc         <= ins.pc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        issue(mk(OPC_LUI, FMT_U, ALU_ADD, 1'b0, 5'd1, 5'd0, 5'd0, 20'h80000, 16'h0100));
        issue(mk(OPC_OP_IMM, FMT_I, ALU_ADD, 1'b0, 5'd2, 5'd0, 5'd0, 20'hFFFFF, 16'h0104));
        issue(mk(OPC_OP_IMM, FMT_I, ALU_ADD, 1'b0, 5'd3, 5'd0, 5'd0, 20'h007FF, 16'h0108));
        for (int f = 0; f < 8; f++)
            issue(mk(OPC_OP, FMT_R, 3'(f), 1'b0, 5'(10 + f), 5'd1, 5'd3, 20'h0, 16'h0200));
        issue(mk(OPC_OP, FMT_R, ALU_ADD, 1'b1, 5'd18, 5'd1, 5'd3, 20'h0, 16'h0300));
        issue(mk(OPC_OP, FMT_R, ALU_SR, 1'b1, 5'd19, 5'd1, 5'd3, 20'h0, 16'h0304));
        // stores: top word via negative address, misaligned half, byte, reserved size
        issue(mk(OPC_STORE, FMT_S, {1'b0, ST_W}, 1'b0, 5'd5, 5'd0, 5'd1, 20'hFFFFC, 16'h0400));
        issue(mk(OPC_STORE, FMT_S, {1'b0, ST_H}, 1'b0, 5'd0, 5'd0, 5'd2, 20'h00003, 16'h0404));
        issue(mk(OPC_STORE, FMT_S, {1'b0, ST_B}, 1'b0, 5'd0, 5'd0, 5'd3, 20'h00001, 16'h0408));
        issue(mk(OPC_STORE, FMT_S, ST_RSVD, 1'b0, 5'd0, 5'd0, 5'd2, 20'h00000, 16'h040C));
        issue(mk(OPC_LOAD, FMT_I, LD_B, 1'b0, 5'd21, 5'd0, 5'd0, 20'h00003, 16'h0500));
        issue(mk(OPC_LOAD, FMT_I, LD_HU, 1'b0, 5'd22, 5'd0, 5'd0, 20'h00003, 16'h0504));
        issue(mk(OPC_LOAD, FMT_I, LD_W, 1'b0, 5'd23, 5'd0, 5'd0, 20'hFFFFC, 16'h0508));
        issue(mk(OPC_LOAD, FMT_I, LD_RSVD, 1'b0, 5'd24, 5'd0, 5'd0, 20'h00000, 16'h050C));
        issue(mk(OPC_BRANCH, FMT_B, BR_EQ, 1'b0, 5'd7, 5'd0, 5'd0, 20'hFFFFF, 16'h0000));
        issue(mk(OPC_BRANCH, FMT_B, BR_RSVD, 1'b0, 5'd7, 5'd1, 5'd3, 20'h00010, 16'h1234));
        issue(mk(OPC_JALR, FMT_I, ALU_ADD, 1'b0, 5'd25, 5'd2, 5'd0, 20'h00000, 16'hFFFC));
        issue(mk(OPC_JAL, FMT_J, ALU_ADD, 1'b0, 5'd26, 5'd0, 5'd0, 20'h7FFFF, 16'hFFFF));
        issue(mk(OPC_OP_IMM, FMT_BAD, ALU_ADD, 1'b0, 5'd28, 5'd1, 5'd2, 20'h00005, 16'h2000));
        issue(mk(OPC_SYSTEM, FMT_I, ALU_ADD, 1'b0, 5'd29, 5'd1, 5'd2, 20'h00005, 16'h8000));
    endtask

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_served != hold_reqs) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("rv32i_execute_stage_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain();

        repeat (250) issue(rand_instr());

        steady <= 1'b1;
        repeat (150) issue(rand_instr());

        // back-pressure: block must fill and stall its input
        hold_reqs <= hold_reqs + 1;
        repeat (100) issue(rand_instr());
        steady <= 1'b0;
        drain();

        repeat (150) issue(rand_instr());
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("rv32i_execute_stage_test: PASS");
        else
            $display("rv32i_execute_stage_test: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rv32i_ex_pkg.sv
hdl/rv32i_ex_ram.sv
hdl/rv32i_ex_exec.sv
hdl/rv32i_ex_dmem.sv
hdl/rv32i_execute_stage.sv
tb/rv32i_execute_checker.sv
tb/rv32i_execute_stage_test.sv
